// File: sv/ccdp_pkg.sv
// Shared types and widths for the complex conjugate dot product core.
// No dependencies; imported by every module of the block.
package ccdp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 32;
    localparam int SHIFT_W  = 5;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_val_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic        [SHIFT_W-1:0]  shift_t;

    // Shifted partial products of one item, handed to the accumulator
    typedef struct packed {
        prod_val_t rr;   // x_re * y_re
        prod_val_t ii;   // x_im * y_im
        prod_val_t ri;   // x_re * y_im
        prod_val_t ir;   // x_im * y_re
        logic      last;
    } prod_t;

endpackage

// File: sv/ccdp_prod_stage.sv
// Input register and partial product stage: four 16x16 multiplies, each
// arithmetically shifted, captured in a product register. Uses ccdp_pkg.
module ccdp_prod_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  ccdp_pkg::shift_t  shift,
    input  logic              in_valid,
    output logic              in_stall,
    input  ccdp_pkg::sample_t x_re,
    input  ccdp_pkg::sample_t x_im,
    input  ccdp_pkg::sample_t y_re,
    input  ccdp_pkg::sample_t y_im,
    input  logic              last,
    output logic              prod_valid,
    output ccdp_pkg::prod_t   prod,
    input  logic              prod_ready
);
    import ccdp_pkg::*;

    logic    in_valid_reg;
    sample_t xr_reg;
    sample_t xi_reg;
    sample_t yr_reg;
    sample_t yi_reg;
    logic    last_reg;

    logic    prod_valid_reg;
    prod_t   prod_reg;
    prod_t   prod_next;

    logic    prod_free;
    logic    in_free;

    prod_val_t p_rr;
    prod_val_t p_ii;
    prod_val_t p_ri;
    prod_val_t p_ir;

    assign prod_free = !prod_valid_reg || prod_ready;
    assign in_free   = !in_valid_reg || prod_free;
    assign in_stall  = !in_free;

    assign p_rr = xr_reg * yr_reg;
    assign p_ii = xi_reg * yi_reg;
    assign p_ri = xr_reg * yi_reg;
    assign p_ir = xi_reg * yr_reg;

    always_comb
    begin
        prod_next.rr   = p_rr >>> shift;
        prod_next.ii   = p_ii >>> shift;
        prod_next.ri   = p_ri >>> shift;
        prod_next.ir   = p_ir >>> shift;
        prod_next.last = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
                in_valid_reg <= in_valid;
            if (prod_free)
                prod_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && in_valid)
        begin
            xr_reg   <= x_re;
            xi_reg   <= x_im;
            yr_reg   <= y_re;
            yi_reg   <= y_im;
            last_reg <= last;
        end
        if (prod_free && in_valid_reg)
            prod_reg <= prod_next;
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

`ifndef ASSERT_OFF
    // a held item in the input register must not vanish while blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !prod_free |=> in_valid_reg)
        else $error("input register dropped a blocked item");

    // a blocked product register keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg && !prod_ready |=> prod_valid_reg && $stable(prod_reg))
        else $error("product register changed while blocked");
`endif

endmodule

// File: sv/ccdp_accum.sv
// Wrapping 32-bit accumulators and the result register.
// Uses ccdp_pkg; fed by ccdp_prod_stage.
module ccdp_accum (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            prod_valid,
    input  ccdp_pkg::prod_t prod,
    output logic            prod_ready,
    output logic            out_valid,
    input  logic            out_stall,
    output ccdp_pkg::acc_t  sum_re,
    output ccdp_pkg::acc_t  sum_im
);
    import ccdp_pkg::*;

    acc_t acc_re_reg;
    acc_t acc_im_reg;
    acc_t acc_re_next;
    acc_t acc_im_next;
    logic out_valid_reg;
    acc_t sum_re_reg;
    acc_t sum_im_reg;

    logic out_free;
    logic take;
    logic emit;

    assign out_free = !out_valid_reg || !out_stall;
    // items that are not last never need the result register
    assign prod_ready = !prod_valid || !prod.last || out_free;
    assign take       = prod_valid && prod_ready;
    assign emit       = take && prod.last;

    assign acc_re_next = acc_re_reg + prod.rr + prod.ii;
    assign acc_im_next = acc_im_reg + prod.ri - prod.ir;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_re_reg    <= '0;
            acc_im_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (prod.last)
                begin
                    acc_re_reg <= '0;
                    acc_im_reg <= '0;
                end
                else
                begin
                    acc_re_reg <= acc_re_next;
                    acc_im_reg <= acc_im_next;
                end
            end
            if (out_free)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sum_re_reg <= acc_re_next;
            sum_im_reg <= acc_im_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sum_re    = sum_re_reg;
    assign sum_im    = sum_im_reg;

`ifndef ASSERT_OFF
    // a vector end leaves both sums cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> acc_re_reg == '0 && acc_im_reg == '0)
        else $error("accumulators not cleared after result");

    // sums move only when an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(acc_re_reg) && $stable(acc_im_reg))
        else $error("accumulator changed without an item");

    // a result is only produced from a last item
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && !emit |=> !out_valid_reg)
        else $error("result appeared without a last item");
`endif

endmodule

// File: sv/complex_conj_dot_product_core.sv
// Throughput: one item per cycle when not stalled; a waiting result blocks only a following last item.
// The path is input register, product register (four 16x16 multiplies), result register.
// Reset (rst_n, async active low) clears both accumulators, the shift register and all valids.
// Uses ccdp_pkg, ccdp_prod_stage and ccdp_accum.
module complex_conj_dot_product_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  ccdp_pkg::shift_t  cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  ccdp_pkg::sample_t x_re,
    input  ccdp_pkg::sample_t x_im,
    input  ccdp_pkg::sample_t y_re,
    input  ccdp_pkg::sample_t y_im,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_stall,
    output ccdp_pkg::acc_t    sum_re,
    output ccdp_pkg::acc_t    sum_im
);
    import ccdp_pkg::*;

    shift_t shift_reg;
    logic   prod_valid;
    prod_t  prod;
    logic   prod_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shift_reg <= '0;
        else if (cfg_we)
            shift_reg <= cfg_wdata;
    end

    ccdp_prod_stage u_prod (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (shift_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .x_re       (x_re),
        .x_im       (x_im),
        .y_re       (y_re),
        .y_im       (y_im),
        .last       (last),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_ready (prod_ready)
    );

    ccdp_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_ready (prod_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sum_re     (sum_re),
        .sum_im     (sum_im)
    );

endmodule

// File: tb/complex_conj_dot_product_core_test.sv
// Testbench for complex_conj_dot_product_core: queued stimulus, bursty valid/stall
// traffic and a bit-exact predictor of the conjugate dot product.
// Depends on ccdp_pkg and the complex_conj_dot_product_core RTL.
module complex_conj_dot_product_core_test;

    import ccdp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS = 170;

    typedef struct {
        sample_t xr;
        sample_t xi;
        sample_t yr;
        sample_t yi;
        logic    last;
    } sample_pair_t;

    typedef struct {
        acc_t re;
        acc_t im;
    } dot_sum_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_we = 1'b0;
    shift_t  cfg_wdata = '0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    sample_t x_re = '0;
    sample_t x_im = '0;
    sample_t y_re = '0;
    sample_t y_im = '0;
    logic    last = 1'b0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    acc_t    sum_re;
    acc_t    sum_im;

    sample_pair_t queued_pairs[$];
    dot_sum_t     expected_sums[$];
    int           failures = 0;
    logic         hold_off_req = 1'b0;

    // predictor state
    acc_t   run_re;
    acc_t   run_im;
    shift_t shift_shadow;

    complex_conj_dot_product_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_re      (x_re),
        .x_im      (x_im),
        .y_re      (y_re),
        .y_im      (y_im),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sum_re    (sum_re),
        .sum_im    (sum_im)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic prod_val_t scaled_product(sample_t a, sample_t b, shift_t s);
        prod_val_t p;
        p = prod_val_t'(a) * prod_val_t'(b);
        return p >>> s;
    endfunction

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // ---------------- driver ----------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        sample_pair_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (queued_pairs.size() > 0)
            begin
                nxt = queued_pairs.pop_front();
                x_re <= nxt.xr;
                x_im <= nxt.xi;
                y_re <= nxt.yr;
                y_im <= nxt.yi;
                last <= nxt.last;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    // mostly short bursts, now and then a long unbroken run
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                            : $urandom_range(1, 30);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left = 0;
                        3:       gap_left = $urandom_range(15, 25);
                        default: gap_left = $urandom_range(1, 8);
                    endcase
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver stall pattern ----------------
    int  mode_left = 0;
    int  stall_mode = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk)
    begin
        logic stall;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            else
            begin
                mode_left--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall = 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0:       stall = 1'b0;
                    1:       stall = ($urandom_range(0, 1) != 0);
                    2:       stall = (mode_left % 4) == 0;
                    default: stall = $urandom_range(0, 4) != 0;
                endcase
            end
            out_stall <= stall;
        end
    end

    // ---------------- monitor: check results, predict accepted items ----------------
    always @(posedge clk)
    begin
        dot_sum_t want;
        if (!rst_n)
        begin
            run_re = '0;
            run_im = '0;
            shift_shadow = '0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_sums.size() == 0)
                begin
                    note_failure($sformatf("result with nothing expected: re=%0d im=%0d",
                                           sum_re, sum_im));
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (sum_re !== want.re)
                        note_failure($sformatf("sum_re expected %0d got %0d", want.re, sum_re));
                    if (sum_im !== want.im)
                        note_failure($sformatf("sum_im expected %0d got %0d", want.im, sum_im));
                end
            end
            if (in_valid && !in_stall)
            begin
                run_re = run_re + scaled_product(x_re, y_re, shift_shadow)
                                + scaled_product(x_im, y_im, shift_shadow);
                run_im = run_im + scaled_product(x_re, y_im, shift_shadow)
                                - scaled_product(x_im, y_re, shift_shadow);
                if (last)
                begin
                    want.re = run_re;
                    want.im = run_im;
                    expected_sums.push_back(want);
                    run_re = '0;
                    run_im = '0;
                end
            end
            if (cfg_we)
                shift_shadow = cfg_wdata;
        end
    end

    // ---------------- watchdog ----------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("complex_conj_dot_product_core: mismatch");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic void add_pair(int xr, int xi, int yr, int yi, bit is_last);
        sample_pair_t p;
        p.xr = sample_t'(xr);
        p.xi = sample_t'(xi);
        p.yr = sample_t'(yr);
        p.yi = sample_t'(yi);
        p.last = is_last;
        queued_pairs.push_back(p);
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(0, 9))
            0:       return -32768;
            1:       return 32767;
            2:       return int'($urandom_range(0, 2)) - 1;
            default: return int'(sample_t'($urandom));
        endcase
    endfunction

    // whole vectors only, so every phase ends on a last item
    task automatic queue_vectors(input int n_items);
        int done;
        int len;
        done = 0;
        while (done < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 12);
            for (int k = 1; k <= len; k++)
                add_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(), k == len);
            done += len;
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (queued_pairs.size() != 0 || in_valid || expected_sums.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_shift(input shift_t value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        shift_t s;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // shift at its reset value: extremes and wrapping sums
        add_pair(32767, 32767, 32767, 32767, 1);
        add_pair(-32768, -32768, -32768, -32768, 1);
        add_pair(-32768, 32767, 32767, -32768, 1);
        add_pair(0, 0, 0, 0, 1);
        for (int k = 0; k < 4; k++)
            add_pair(-32768, 32767, -32768, -32768, k == 3);
        add_pair(1, -1, -1, 1, 0);
        add_pair(-1, 1, 1, -1, 1);
        wait_idle();

        // largest shift: negative products floor to -1
        write_shift(shift_t'(31));
        add_pair(-32768, -32768, 32767, 32767, 1);
        add_pair(32767, -32768, 32767, -32768, 0);
        add_pair(-1, -1, 1, 1, 1);
        wait_idle();

        // odd products under a shift of one round toward minus infinity
        write_shift(shift_t'(1));
        add_pair(3, -3, -5, 5, 1);
        add_pair(-32768, -32768, -32768, -32768, 1);
        add_pair(1, 1, 1, 1, 0);
        add_pair(-1, 1, 1, 1, 1);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       s = shift_t'(0);
                1:       s = shift_t'(31);
                2:       s = shift_t'(16);
                4:       s = shift_t'(1);
                6:       s = shift_t'(30);
                default: s = shift_t'($urandom_range(0, 31));
            endcase
            write_shift(s);
            queue_vectors(PHASE_ITEMS);
            if (ph == 2)
                hold_off_req = 1'b1;
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("complex_conj_dot_product_core: match");
        else
            $display("complex_conj_dot_product_core: mismatch");
        $finish;
    end

endmodule

// File: files.f
sv/ccdp_pkg.sv
sv/ccdp_prod_stage.sv
sv/ccdp_accum.sv
sv/complex_conj_dot_product_core.sv
tb/complex_conj_dot_product_core_test.sv
